/* hw/rtl/cde_pkg.sv */
// Shared constants, request codes and control types for the circular deque engine.
`timescale 1ns / 1ps
`default_nettype none

package cde_pkg;

  // Storage geometry.
  localparam int unsigned DEPTH     = 128;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

  // Port field widths.
  localparam int unsigned KIND_W = 3;
  localparam int unsigned DATA_W = 32;

  // Value returned with a failed request.
  localparam logic [DATA_W-1:0] ERR_VALUE = '1;

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_FRONT      = 3'd4,
    REQ_BACK       = 3'd5,
    REQ_SIZE       = 3'd6,
    REQ_EMPTY      = 3'd7
  } req_kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;   // execute the request presented on the input channel
    logic load;   // load the result register
  } cde_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_result;  // the presented request gives a result item
    logic empty;
    logic full;
  } cde_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/cde_req_if.sv */
// Request channel interface of the circular deque engine.
`timescale 1ns / 1ps
`default_nettype none

interface cde_req_if;
  logic                                  valid;
  logic                                  ready;
  logic        [cde_pkg::KIND_W-1:0]     req_type;
  logic signed [cde_pkg::DATA_W-1:0]     push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink   (input valid, req_type, push_value, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cde_rsp_if.sv */
// Result channel interface of the circular deque engine.
`timescale 1ns / 1ps
`default_nettype none

interface cde_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [cde_pkg::DATA_W-1:0] read_value;
  logic                              failed;

  modport source (output valid, read_value, failed, input ready);
  modport sink   (input valid, read_value, failed, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cde_ctrl.sv */
// Controller state machine of the circular deque engine.
`timescale 1ns / 1ps
`default_nettype none

module cde_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire cde_pkg::cde_sts_t sts_i,
  output cde_pkg::cde_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEND
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   accept;

  assign accept      = in_valid_i && in_ready_q;
  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  // Commands: execute on acceptance, capture the result of a request that gives one in the cycle after acceptance.
  always_comb begin
    cmd_o.exec = accept;
    cmd_o.load = (state_q == ST_LOAD);
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && sts_i.need_result) begin
            in_ready_q <= 1'b0;
            state_q    <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_SEND;
        end
        ST_SEND: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cde_dp.sv */
// Datapath of the circular deque engine: storage, pointers, count and result register.
`timescale 1ns / 1ps
`default_nettype none

module cde_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire cde_pkg::cde_cmd_t                  cmd_i,
  output cde_pkg::cde_sts_t                       sts_o,
  input  wire logic        [cde_pkg::KIND_W-1:0]  req_type_i,
  input  wire logic signed [cde_pkg::DATA_W-1:0]  push_value_i,
  output logic signed      [cde_pkg::DATA_W-1:0]  read_value_o,
  output logic                                    failed_o
);

  logic        [cde_pkg::WORD_BITS-1:0] mem_q [cde_pkg::DEPTH];
  logic        [cde_pkg::PTR_W-1:0]     head_q;
  logic        [cde_pkg::PTR_W-1:0]     tail_q;
  logic        [cde_pkg::CNT_W-1:0]     occ_q;
  logic signed [cde_pkg::WORD_BITS-1:0] rd_data_q;
  cde_pkg::req_kind_e                   kind_q;
  logic                                 fail_q;
  logic signed [cde_pkg::DATA_W-1:0]    res_value_q;
  logic                                 res_failed_q;

  cde_pkg::req_kind_e                   kind;
  logic                                 is_push;
  logic                                 is_pop;
  logic                                 is_peek;
  logic                                 is_info;
  logic                                 empty;
  logic                                 full;
  logic                                 fail_now;
  logic        [cde_pkg::PTR_W-1:0]     head_inc;
  logic        [cde_pkg::PTR_W-1:0]     head_dec;
  logic        [cde_pkg::PTR_W-1:0]     tail_inc;
  logic        [cde_pkg::PTR_W-1:0]     tail_dec;
  logic        [cde_pkg::PTR_W-1:0]     wr_addr;
  logic        [cde_pkg::PTR_W-1:0]     rd_addr;
  logic signed [cde_pkg::WORD_BITS-1:0] wr_word;
  logic signed [cde_pkg::DATA_W-1:0]    res_value;

  assign kind  = cde_pkg::req_kind_e'(req_type_i);
  assign empty = (occ_q == '0);
  assign full  = (occ_q == cde_pkg::CNT_W'(cde_pkg::DEPTH));

  // Request decode.
  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    is_peek = 1'b0;
    is_info = 1'b0;
    unique case (kind) inside
      cde_pkg::REQ_PUSH_FRONT, cde_pkg::REQ_PUSH_BACK: is_push = 1'b1;
      cde_pkg::REQ_POP_FRONT, cde_pkg::REQ_POP_BACK:   is_pop  = 1'b1;
      cde_pkg::REQ_FRONT, cde_pkg::REQ_BACK:           is_peek = 1'b1;
      default:                                         is_info = 1'b1;
    endcase
  end

  assign fail_now = (is_push && full) || ((is_pop || is_peek) && empty);

  always_comb begin
    sts_o.need_result = fail_now || is_peek || is_info;
    sts_o.empty       = empty;
    sts_o.full        = full;
  end

  // Pointer arithmetic with explicit wrap, so any depth works.
  assign head_inc = (head_q == cde_pkg::PTR_W'(cde_pkg::DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? cde_pkg::PTR_W'(cde_pkg::DEPTH - 1) : head_q - 1'b1;
  assign tail_inc = (tail_q == cde_pkg::PTR_W'(cde_pkg::DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign tail_dec = (tail_q == '0) ? cde_pkg::PTR_W'(cde_pkg::DEPTH - 1) : tail_q - 1'b1;

  assign wr_addr = (kind == cde_pkg::REQ_PUSH_FRONT) ? head_dec : tail_q;
  assign rd_addr = (kind == cde_pkg::REQ_FRONT) ? head_q : tail_dec;
  assign wr_word = cde_pkg::WORD_BITS'(push_value_i);

  // Pointers and entry count; a failed request leaves them untouched.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
    end else if (cmd_i.exec && !fail_now) begin
      case (kind)
        cde_pkg::REQ_PUSH_FRONT: begin
          head_q <= head_dec;
          occ_q  <= occ_q + 1'b1;
        end
        cde_pkg::REQ_PUSH_BACK: begin
          tail_q <= tail_inc;
          occ_q  <= occ_q + 1'b1;
        end
        cde_pkg::REQ_POP_FRONT: begin
          head_q <= head_inc;
          occ_q  <= occ_q - 1'b1;
        end
        cde_pkg::REQ_POP_BACK: begin
          tail_q <= tail_dec;
          occ_q  <= occ_q - 1'b1;
        end
        default: begin
          occ_q <= occ_q;
        end
      endcase
    end
  end

  // Storage: one write port for pushes, one registered read port for peeks.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && is_push && !full) begin
      mem_q[wr_addr] <= wr_word;
    end
    if (cmd_i.exec) begin
      rd_data_q <= mem_q[rd_addr];
      kind_q    <= kind;
      fail_q    <= fail_now;
    end
  end

  // Result selection from the captured request.
  always_comb begin
    res_value = cde_pkg::DATA_W'(rd_data_q);
    if (fail_q) begin
      res_value = cde_pkg::ERR_VALUE;
    end else begin
      case (kind_q) inside
        cde_pkg::REQ_SIZE:  res_value = cde_pkg::DATA_W'(occ_q);
        cde_pkg::REQ_EMPTY: res_value = cde_pkg::DATA_W'(empty);
        default:            res_value = cde_pkg::DATA_W'(rd_data_q);
      endcase
    end
  end

  // Result register, held until the item is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_value_q  <= res_value;
      res_failed_q <= fail_q;
    end
  end

  assign read_value_o = res_value_q;
  assign failed_o     = res_failed_q;

endmodule

`default_nettype wire

/* hw/rtl/circular_deque_engine.sv */
// Push and pop without error complete on acceptance and give no result item.
// A request that gives a result passes the read register, the load state and
// the result register; its item is held until taken and blocks new requests till then.
// One push or pop is accepted per cycle while no result item is pending.
// Reset (asynchronous, active low) empties the deque; the storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque_engine (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cde_req_if.sink   req_i,
  cde_rsp_if.source rsp_o
);

  cde_pkg::cde_cmd_t cmd;
  cde_pkg::cde_sts_t sts;

  // Controller.
  cde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  cde_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_i.req_type),
    .push_value_i (req_i.push_value),
    .read_value_o (rsp_o.read_value),
    .failed_o     (rsp_o.failed)
  );

  // A pending result item blocks new requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !req_i.ready)
    else $error("request accepted while a result item is pending");

  // A request that gives a result closes the input on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && sts.need_result) |=> !req_i.ready)
    else $error("input stayed open after a request with a result");

  // The deque is never empty and full together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sts.empty && sts.full))
    else $error("deque is empty and full at once");

  // The item is first shown in the cycle after the result register is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> (rsp_o.valid && !$past(rsp_o.valid)))
    else $error("result item not shown after load");

endmodule

`default_nettype wire
